>>> sv/sclr_pkg.sv
// Shared types and constants for the serial command line recognizer.
// Holds the command text table, event codes and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package sclr_pkg;

    localparam int LINE_BUFFER_SIZE_DEF = 64;
    localparam int CMD_COUNT            = 5;
    localparam int CMD_MAXLEN           = 12;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    localparam logic [2:0] EV_MODE_QUERY   = 3'd0;
    localparam logic [2:0] EV_MODE_CS      = 3'd1;
    localparam logic [2:0] EV_MODE_BLE     = 3'd2;
    localparam logic [2:0] EV_MODE_DEFAULT = 3'd3;
    localparam logic [2:0] EV_HELP         = 3'd4;
    localparam logic [2:0] EV_UNKNOWN      = 3'd5;
    localparam logic [2:0] EV_BLANK        = 3'd6;
    localparam logic [2:0] EV_TOO_LONG     = 3'd7;

    // Command strings, padded with zeros past their length.
    localparam logic [7:0] CMD_TEXT [CMD_COUNT][CMD_MAXLEN] = '{
        '{"m", "o", "d", "e", "?", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"m", "o", "d", "e", "=", "c", "s", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"m", "o", "d", "e", "=", "b", "l", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"m", "o", "d", "e", "=", "d", "e", "f", "a", "u", "l", "t"},
        '{"h", "e", "l", "p", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{4'd5, 4'd7, 4'd8, 4'd12, 4'd4};

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
        logic [5:0] length;
    } t_result;

endpackage

>>> sv/sclr_line_core.sv
// Line state and per-byte command matching for the recognizer.
// Holds the byte count, candidate flags and zero flags; emits one result.
// Depends on sclr_pkg.
`timescale 1ns / 1ps

module sclr_line_core
    import sclr_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    localparam int CW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CW-1:0] LAST_SLOT = CW'(LINE_BUFFER_SIZE - 1);

    logic [CW-1:0]        r_held, n_held;
    logic [CMD_COUNT-1:0] r_flags, n_flags;
    logic                 r_zero_seen, n_zero_seen;
    logic                 r_first_zero, n_first_zero;

    logic [CMD_COUNT-1:0] len_mask;
    logic [CMD_COUNT-1:0] byte_mask;
    logic [CMD_COUNT-1:0] end_flags;
    logic [2:0]           pick;
    logic                 is_term;

    assign is_term = (i_byte == CHAR_CR) || (i_byte == CHAR_LF);

    always_comb begin
        for (int k = 0; k < CMD_COUNT; k++) begin
            len_mask[k]  = (CW'(CMD_LEN[k]) == r_held);
            byte_mask[k] = (r_held < CW'(CMD_LEN[k]))
                        && (CMD_TEXT[k][r_held[3:0]] == i_byte);
        end
    end

    assign end_flags = r_zero_seen ? r_flags : (r_flags & len_mask);

    // Lowest-numbered surviving command wins.
    always_comb begin
        pick = EV_UNKNOWN;
        for (int k = CMD_COUNT - 1; k >= 0; k--) begin
            if (end_flags[k]) begin
                pick = 3'(k);
            end
        end
    end

    always_comb begin
        n_held       = r_held;
        n_flags      = r_flags;
        n_zero_seen  = r_zero_seen;
        n_first_zero = r_first_zero;
        o_result     = '{valid: 1'b0, code: EV_UNKNOWN, length: 6'd0};
        if (i_step) begin
            if (is_term) begin
                if (r_held != '0) begin
                    o_result.valid  = 1'b1;
                    o_result.code   = r_first_zero ? EV_BLANK : pick;
                    o_result.length = 6'(r_held);
                    n_held          = '0;
                    n_flags         = '1;
                    n_zero_seen     = 1'b0;
                    n_first_zero    = 1'b0;
                end
            end else if (r_held == LAST_SLOT) begin
                // drop the line, discard this byte
                o_result.valid  = 1'b1;
                o_result.code   = EV_TOO_LONG;
                o_result.length = 6'd0;
                n_held          = '0;
                n_flags         = '1;
                n_zero_seen     = 1'b0;
                n_first_zero    = 1'b0;
            end else begin
                if (!r_zero_seen) begin
                    if (i_byte == 8'd0) begin
                        n_zero_seen  = 1'b1;
                        n_first_zero = (r_held == '0);
                        n_flags      = r_flags & len_mask;
                    end else begin
                        n_flags      = r_flags & byte_mask;
                    end
                end
                n_held = r_held + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_flags      <= '1;
            r_zero_seen  <= 1'b0;
            r_first_zero <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_flags      <= n_flags;
            r_zero_seen  <= n_zero_seen;
            r_first_zero <= n_first_zero;
        end
    end

endmodule

>>> sv/serial_command_line_recognizer_unit.sv
// Serial command line recognizer: one received byte per request in,
// one event per completed line out. Top level; uses sclr_pkg and sclr_line_core.
//
// Usage:
//   Input channel  i_rx_valid / o_rx_ready carries i_rx_byte. CR or LF ends a
//   line; an empty line produces nothing. Output channel o_res_valid /
//   i_res_ready carries o_event_code and o_line_length for each non-empty
//   line, or a too-long event when a byte arrives with the buffer full.
//   An accepted byte is registered in the input register, then processed
//   against the line state when it advances; its event is registered in the
//   output register and held there until i_res_ready takes it.
//   Throughput: one byte per cycle unless an event stalls in the output
//   register. Bytes pass the input register, line update and output register.
//   Stall: while an event waits in the output register, the byte waiting in
//   the input register holds; the input still accepts while that register is
//   empty or moving, so o_rx_ready depends on i_res_ready combinationally.
//   Reset: synchronous, active low. Clears the line (count zero, all commands
//   possible) and empties both registers; o_rx_ready is high after reset.
`timescale 1ns / 1ps

module serial_command_line_recognizer_unit
    import sclr_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_code,
    output logic [5:0] o_line_length
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [2:0] r_out_code;
    logic [5:0] r_out_len;
    logic       advance;
    t_result    step_result;

    // Move the held byte through only when the output register can take a result.
    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    sclr_line_core #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_result(step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_result.valid;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_result.valid) begin
            r_out_code <= step_result.code;
            r_out_len  <= step_result.length;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_event_code  = r_out_code;
    assign o_line_length = r_out_len;

endmodule

>>> sv/sclr_checker.sv
// Port-level checks for serial_command_line_recognizer_unit.
// Bound to the top level below; depends on sclr_pkg.
`timescale 1ns / 1ps

module sclr_checker
    import sclr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [2:0] o_event_code,
    input logic [5:0] o_line_length
);

    // A stalled result holds its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_event_code)
            && $stable(o_line_length))
        else $error("result changed while stalled");

    // A refused request stays offered with the same byte.
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_valid && !o_rx_ready |=> i_rx_valid && $stable(i_rx_byte))
        else $error("request changed while refused");

    a_too_long_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_event_code == EV_TOO_LONG) |-> (o_line_length == 6'd0))
        else $error("too-long event with nonzero length");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_rx_ready)
        else $error("input not ready right after reset");

endmodule

bind serial_command_line_recognizer_unit sclr_checker u_sclr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_valid   (i_rx_valid),
    .o_rx_ready   (o_rx_ready),
    .i_rx_byte    (i_rx_byte),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_event_code (o_event_code),
    .o_line_length(o_line_length)
);
